// ===== src/spi_pkg.sv =====
// shared types, widths and result codes for the segment pair intersection core
// no dependencies
package spi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int OUT_W      = 32;

  localparam int DIFF_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W;
  localparam int DVD_W   = MAG_W + DIFF_W + FRAC_BITS;

  // quotient never exceeds |b-a| scaled by the fraction bits
  localparam int QUOT_BITS  = DIFF_W + FRAC_BITS;
  localparam int STEP_BITS  = 3;
  localparam int DIV_STAGES = (QUOT_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int QP_W       = DIV_STAGES * STEP_BITS;

  typedef enum logic [2:0] {
    KIND_CALC = 3'd0,
    KIND_AB   = 3'd1,
    KIND_CD   = 3'd2,
    KIND_ZERO = 3'd3,
    KIND_NONE = 3'd4
  } kind_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] ax;
    logic signed [COORD_BITS-1:0] ay;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [COORD_BITS-1:0] dx;
    logic signed [COORD_BITS-1:0] dy;
  } in_t;

  typedef struct packed {
    logic [2:0]              kind;
    logic signed [OUT_W-1:0] px;
    logic signed [OUT_W-1:0] py;
  } out_t;

  // word carried through the divider stages
  typedef struct packed {
    kind_t                        kind;
    logic signed [COORD_BITS-1:0] basex;
    logic signed [COORD_BITS-1:0] basey;
    logic                         negx;
    logic                         negy;
    logic [MAG_W-1:0]             den;
    logic [MAG_W-1:0]             remx;
    logic [MAG_W-1:0]             remy;
    logic [QP_W-1:0]              lowx;
    logic [QP_W-1:0]              lowy;
    logic [QP_W-1:0]              qx;
    logic [QP_W-1:0]              qy;
  } div_t;

endpackage

// ===== src/spi_front.sv =====
// front pipeline: differences, products, cross terms, classification, dividends
// depends on spi_pkg
module spi_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spi_pkg::in_t  req,
  output logic          valid,
  input  logic          adv,
  output spi_pkg::div_t data
);

  localparam int CW = spi_pkg::COORD_BITS;
  localparam int DW = spi_pkg::DIFF_W;
  localparam int PW = spi_pkg::PROD_W;
  localparam int XW = spi_pkg::CROSS_W;
  localparam int MW = spi_pkg::MAG_W;

  logic v1, v2, v3, v4;
  logic e1, e2, e3, e4, e5;

  assign e5 = !valid || adv;
  assign e4 = !v4 || e5;
  assign e3 = !v3 || e4;
  assign e2 = !v2 || e3;
  assign e1 = !v1 || e2;
  assign req_ready = e1;

  // stage 1: differences
  spi_pkg::in_t s1_pt;
  logic signed [DW-1:0] bax, bay, dcx, dcy, cax, cay, dax, day, acx, acy, bcx, bcy;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (e1) v1 <= req_valid;
    if (e1) begin
      s1_pt <= req;
      bax <= DW'(req.bx) - DW'(req.ax);
      bay <= DW'(req.by) - DW'(req.ay);
      dcx <= DW'(req.dx) - DW'(req.cx);
      dcy <= DW'(req.dy) - DW'(req.cy);
      cax <= DW'(req.cx) - DW'(req.ax);
      cay <= DW'(req.cy) - DW'(req.ay);
      dax <= DW'(req.dx) - DW'(req.ax);
      day <= DW'(req.dy) - DW'(req.ay);
      acx <= DW'(req.ax) - DW'(req.cx);
      acy <= DW'(req.ay) - DW'(req.cy);
      bcx <= DW'(req.bx) - DW'(req.cx);
      bcy <= DW'(req.by) - DW'(req.cy);
    end
  end

  // stage 2: products
  spi_pkg::in_t s2_pt;
  logic signed [DW-1:0] s2_bax, s2_bay;
  logic signed [PW-1:0] pc0, pc1, pd0, pd1, pa0, pa1, pb0, pb1, pn0, pn1, pe0, pe1;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (e2) v2 <= v1;
    if (e2) begin
      s2_pt  <= s1_pt;
      s2_bax <= bax;
      s2_bay <= bay;
      pc0 <= bax * cay;
      pc1 <= bay * cax;
      pd0 <= bax * day;
      pd1 <= bay * dax;
      pa0 <= dcx * acy;
      pa1 <= dcy * acx;
      pb0 <= dcx * bcy;
      pb1 <= dcy * bcx;
      pn0 <= dcx * cay;
      pn1 <= dcy * cax;
      pe0 <= dcx * bay;
      pe1 <= dcy * bax;
    end
  end

  // stage 3: cross terms
  spi_pkg::in_t s3_pt;
  logic signed [DW-1:0] s3_bax, s3_bay;
  logic signed [XW-1:0] xc, xd, xa, xb, xnum, xden;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (e3) v3 <= v2;
    if (e3) begin
      s3_pt  <= s2_pt;
      s3_bax <= s2_bax;
      s3_bay <= s2_bay;
      xc   <= XW'(pc0) - XW'(pc1);
      xd   <= XW'(pd0) - XW'(pd1);
      xa   <= XW'(pa0) - XW'(pa1);
      xb   <= XW'(pb0) - XW'(pb1);
      xnum <= XW'(pn0) - XW'(pn1);
      xden <= XW'(pe0) - XW'(pe1);
    end
  end

  // stage 4: classification and magnitudes
  logic [1:0] oa, ob, oc, od;
  spi_pkg::kind_t kind_c;
  logic signed [CW-1:0] bsx_c, bsy_c;

  function automatic logic [1:0] sgn(input logic signed [XW-1:0] v);
    logic [1:0] r;
    if (v == '0) r = 2'd0;
    else if (v[XW-1]) r = 2'd2;
    else r = 2'd1;
    return r;
  endfunction

  assign oa = sgn(xa);
  assign ob = sgn(xb);
  assign oc = sgn(xc);
  assign od = sgn(xd);

  always_comb begin
    kind_c = spi_pkg::KIND_NONE;
    bsx_c  = s3_pt.ax;
    bsy_c  = s3_pt.ay;
    if (oc != od && oa != ob) begin
      if (oc == 2'd0) begin
        kind_c = spi_pkg::KIND_CD; bsx_c = s3_pt.cx; bsy_c = s3_pt.cy;
      end else if (od == 2'd0) begin
        kind_c = spi_pkg::KIND_CD; bsx_c = s3_pt.dx; bsy_c = s3_pt.dy;
      end else if (oa == 2'd0) begin
        kind_c = spi_pkg::KIND_AB;
      end else if (ob == 2'd0) begin
        kind_c = spi_pkg::KIND_AB; bsx_c = s3_pt.bx; bsy_c = s3_pt.by;
      end else if (xden == '0) begin
        kind_c = spi_pkg::KIND_ZERO;
      end else begin
        kind_c = spi_pkg::KIND_CALC;
      end
    end
  end

  spi_pkg::kind_t s4_kind;
  logic signed [CW-1:0] s4_bsx, s4_bsy;
  logic s4_negx, s4_negy;
  logic [MW-1:0] s4_num, s4_den;
  logic [DW-1:0] s4_mx, s4_my;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (e4) v4 <= v3;
    if (e4) begin
      s4_kind <= kind_c;
      s4_bsx  <= bsx_c;
      s4_bsy  <= bsy_c;
      s4_negx <= xnum[XW-1] ^ s3_bax[DW-1] ^ xden[XW-1];
      s4_negy <= xnum[XW-1] ^ s3_bay[DW-1] ^ xden[XW-1];
      s4_num  <= MW'(xnum[XW-1] ? -xnum : xnum);
      s4_den  <= MW'(xden[XW-1] ? -xden : xden);
      s4_mx   <= DW'(s3_bax[DW-1] ? -s3_bax : s3_bax);
      s4_my   <= DW'(s3_bay[DW-1] ? -s3_bay : s3_bay);
    end
  end

  // stage 5: scaled dividends
  logic [spi_pkg::DVD_W-1:0] dvdx, dvdy;

  assign dvdx = spi_pkg::DVD_W'(s4_num * s4_mx) << spi_pkg::FRAC_BITS;
  assign dvdy = spi_pkg::DVD_W'(s4_num * s4_my) << spi_pkg::FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (e5) valid <= v4;
    if (e5) begin
      data.kind  <= s4_kind;
      data.basex <= s4_bsx;
      data.basey <= s4_bsy;
      data.negx  <= s4_negx;
      data.negy  <= s4_negy;
      data.den   <= s4_den;
      data.remx  <= MW'(dvdx >> spi_pkg::QP_W);
      data.remy  <= MW'(dvdy >> spi_pkg::QP_W);
      data.lowx  <= spi_pkg::QP_W'(dvdx);
      data.lowy  <= spi_pkg::QP_W'(dvdy);
      data.qx    <= '0;
      data.qy    <= '0;
    end
  end

endmodule

// ===== src/spi_div_stage.sv =====
// one stage of the restoring divider, three quotient bits for x and y
// depends on spi_pkg
module spi_div_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          en,
  input  spi_pkg::div_t in_data,
  output logic          valid,
  input  logic          adv,
  output spi_pkg::div_t data
);

  localparam int MW = spi_pkg::MAG_W;
  localparam int QW = spi_pkg::QP_W;

  spi_pkg::div_t nxt;
  logic [MW:0] rx, ry;

  assign en = !valid || adv;

  always_comb begin
    nxt = in_data;
    rx  = '0;
    ry  = '0;
    for (int i = 0; i < spi_pkg::STEP_BITS; i++) begin
      rx = {nxt.remx, nxt.lowx[QW-1]};
      ry = {nxt.remy, nxt.lowy[QW-1]};
      nxt.lowx = nxt.lowx << 1;
      nxt.lowy = nxt.lowy << 1;
      if (rx >= {1'b0, nxt.den}) begin
        rx = rx - {1'b0, nxt.den};
        nxt.qx = {nxt.qx[QW-2:0], 1'b1};
      end else begin
        nxt.qx = {nxt.qx[QW-2:0], 1'b0};
      end
      if (ry >= {1'b0, nxt.den}) begin
        ry = ry - {1'b0, nxt.den};
        nxt.qy = {nxt.qy[QW-2:0], 1'b1};
      end else begin
        nxt.qy = {nxt.qy[QW-2:0], 1'b0};
      end
      nxt.remx = MW'(rx);
      nxt.remy = MW'(ry);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (en) valid <= in_valid;
    if (en) data <= nxt;
  end

endmodule

// ===== src/segment_pair_intersection_core.sv =====
// segment pair intersection core: exact orientation tests, fixed point crossing
// pipeline of 5 front stages, 11 divider stages, 1 output stage
// throughput one word per cycle unless rsp_ready stalls; each stage holds only while its successor is full
// rst is synchronous: clears all valid bits, payload registers are not reset
// depends on spi_pkg, spi_front, spi_div_stage
module segment_pair_intersection_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  spi_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output spi_pkg::out_t rsp
);

  localparam int NS = spi_pkg::DIV_STAGES;
  localparam int OW = spi_pkg::OUT_W;

  logic          sv  [0:NS];
  logic          sen [0:NS];
  spi_pkg::div_t sd  [0:NS];
  logic          en_out;

  assign en_out  = !rsp_valid || rsp_ready;
  assign sen[NS] = en_out;

  spi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .valid     (sv[0]),
    .adv       (sen[0]),
    .data      (sd[0])
  );

  for (genvar g = 0; g < NS; g++) begin : g_div
    spi_div_stage u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (sv[g]),
      .en       (sen[g]),
      .in_data  (sd[g]),
      .valid    (sv[g+1]),
      .adv      (sen[g+1]),
      .data     (sd[g+1])
    );
  end

  spi_pkg::div_t        last;
  logic signed [OW-1:0] fx, fy, qx, qy;
  spi_pkg::out_t        res;

  assign last = sd[NS];
  assign fx = OW'(last.basex) << spi_pkg::FRAC_BITS;
  assign fy = OW'(last.basey) << spi_pkg::FRAC_BITS;
  assign qx = OW'(last.qx);
  assign qy = OW'(last.qy);

  always_comb begin
    res.kind = last.kind;
    res.px   = '0;
    res.py   = '0;
    case (last.kind)
      spi_pkg::KIND_CALC: begin
        res.px = last.negx ? fx - qx : fx + qx;
        res.py = last.negy ? fy - qy : fy + qy;
      end
      spi_pkg::KIND_AB, spi_pkg::KIND_CD: begin
        res.px = fx;
        res.py = fy;
      end
      default: begin
        res.px = '0;
        res.py = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (en_out) rsp_valid <= sv[NS];
    if (en_out) rsp <= res;
  end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for segment_pair_intersection_core
// depends on spi_pkg, core; directed then random pairs, checked vs golden or predictor
`timescale 1ns / 1ps

module testbench;

  localparam int N_RANDOM = 1000;
  localparam int N_DIRECTED = 12;

  logic          clk;
  logic          rst;
  logic          req_valid;
  logic          req_ready;
  spi_pkg::in_t  req;
  logic          rsp_valid;
  logic          rsp_ready;
  spi_pkg::out_t rsp;

  spi_pkg::out_t expected_q[$];
  int   err_cnt;
  bit   quiet_phase;
  bit   stim_done;

  segment_pair_intersection_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  // orientation sign of r against line pq: 0 collinear, 1 left, 2 right
  function automatic int side_of(longint px, longint py, longint qx, longint qy,
                                 longint rx, longint ry);
    longint v;
    v = (qx - px) * (ry - py) - (qy - py) * (rx - px);
    if (v == 0) return 0;
    return (v < 0) ? 2 : 1;
  endfunction

  function automatic logic [31:0] crossing_coord(longint a, longint b, longint num,
                                                 longint den);
    logic signed [127:0] prod;
    logic signed [127:0] q;
    prod = (128'(signed'(num)) * 128'(signed'(b - a))) <<< spi_pkg::FRAC_BITS;
    q = prod / 128'(signed'(den));  // truncates toward zero
    return 32'((128'(signed'(a)) <<< spi_pkg::FRAC_BITS) + q);
  endfunction

  function automatic spi_pkg::out_t crossing_of(spi_pkg::in_t w);
    longint ax, ay, bx, by, cx, cy, dx, dy, den, num;
    int oa, ob, oc, od;
    spi_pkg::out_t r;
    ax = w.ax; ay = w.ay; bx = w.bx; by = w.by;
    cx = w.cx; cy = w.cy; dx = w.dx; dy = w.dy;
    oa = side_of(cx, cy, dx, dy, ax, ay);
    ob = side_of(cx, cy, dx, dy, bx, by);
    oc = side_of(ax, ay, bx, by, cx, cy);
    od = side_of(ax, ay, bx, by, dx, dy);
    r.kind = spi_pkg::KIND_NONE;
    r.px = '0;
    r.py = '0;
    if (oc != od && oa != ob) begin
      if (oc == 0) begin
        r.kind = spi_pkg::KIND_CD;
        r.px = 32'(cx <<< spi_pkg::FRAC_BITS); r.py = 32'(cy <<< spi_pkg::FRAC_BITS);
      end else if (od == 0) begin
        r.kind = spi_pkg::KIND_CD;
        r.px = 32'(dx <<< spi_pkg::FRAC_BITS); r.py = 32'(dy <<< spi_pkg::FRAC_BITS);
      end else if (oa == 0) begin
        r.kind = spi_pkg::KIND_AB;
        r.px = 32'(ax <<< spi_pkg::FRAC_BITS); r.py = 32'(ay <<< spi_pkg::FRAC_BITS);
      end else if (ob == 0) begin
        r.kind = spi_pkg::KIND_AB;
        r.px = 32'(bx <<< spi_pkg::FRAC_BITS); r.py = 32'(by <<< spi_pkg::FRAC_BITS);
      end else begin
        den = ax * (dy - cy) + bx * (cy - dy) + dx * (by - ay) + cx * (ay - by);
        num = ax * (dy - cy) + cx * (ay - dy) + dx * (cy - ay);
        if (den == 0) begin
          r.kind = spi_pkg::KIND_ZERO;
        end else begin
          r.kind = spi_pkg::KIND_CALC;
          r.px = crossing_coord(ax, bx, num, den);
          r.py = crossing_coord(ay, by, num, den);
        end
      end
    end
    return r;
  endfunction

  // directed pairs: {ax,ay,bx,by,cx,cy,dx,dy}
  spi_pkg::in_t  seg_table[N_DIRECTED];
  spi_pkg::out_t seg_golden[N_DIRECTED];
  bit            seg_has_golden[N_DIRECTED];

  initial begin
    seg_table[0]  = '{0, 0, 0, 0, 0, 0, 0, 0};            // all degenerate
    seg_golden[0] = '{spi_pkg::KIND_NONE, 0, 0}; seg_has_golden[0] = 1;
    seg_table[1]  = '{-10, 0, 10, 0, 0, -10, 0, 10};      // plain cross at origin
    seg_golden[1] = '{spi_pkg::KIND_CALC, 0, 0}; seg_has_golden[1] = 1;
    seg_table[2]  = '{-10, 0, 10, 0, 3, 0, 3, 10};        // c on ab
    seg_golden[2] = '{spi_pkg::KIND_CD, 3 << 16, 0}; seg_has_golden[2] = 1;
    seg_table[3]  = '{-10, 0, 10, 0, 5, 10, 5, 0};        // d on ab
    seg_golden[3] = '{spi_pkg::KIND_CD, 5 << 16, 0}; seg_has_golden[3] = 1;
    seg_table[4]  = '{0, 0, 0, 10, -5, 0, 5, 0};          // a on cd
    seg_golden[4] = '{spi_pkg::KIND_AB, 0, 0}; seg_has_golden[4] = 1;
    seg_table[5]  = '{0, 10, 2, 0, -5, 0, 5, 0};          // b on cd
    seg_golden[5] = '{spi_pkg::KIND_AB, 2 << 16, 0}; seg_has_golden[5] = 1;
    seg_table[6]  = '{0, 0, 10, 0, 0, 5, 10, 5};          // parallel, apart
    seg_golden[6] = '{spi_pkg::KIND_NONE, 0, 0}; seg_has_golden[6] = 1;
    seg_table[7]  = '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768};
    seg_has_golden[7] = 0;
    seg_table[8]  = '{32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767};
    seg_has_golden[8] = 0;
    seg_table[9]  = '{-1, -1, -1, -1, -1, -1, -1, -1};
    seg_golden[9] = '{spi_pkg::KIND_NONE, 0, 0}; seg_has_golden[9] = 1;
    seg_table[10] = '{0, 0, 3, 1, 0, 1, 2, 0};            // fractional crossing
    seg_has_golden[10] = 0;
    seg_table[11] = '{-32768, 0, 32767, 1, 5, -32768, -7, 32767};
    seg_has_golden[11] = 0;
  end

  function automatic spi_pkg::in_t random_pair();
    spi_pkg::in_t w;
    int mode;
    mode = $urandom_range(0, 9);
    w = spi_pkg::in_t'({$urandom, $urandom, $urandom, $urandom});
    if (mode < 3) begin
      // small coordinates hit collinear and parallel cases often
      w.ax = $urandom_range(0, 8) - 4; w.ay = $urandom_range(0, 8) - 4;
      w.bx = $urandom_range(0, 8) - 4; w.by = $urandom_range(0, 8) - 4;
      w.cx = $urandom_range(0, 8) - 4; w.cy = $urandom_range(0, 8) - 4;
      w.dx = $urandom_range(0, 8) - 4; w.dy = $urandom_range(0, 8) - 4;
    end else if (mode < 7) begin
      // mirror c through about the midpoint of ab so that cd likely crosses ab
      w.cx = w.ax / 2 + w.bx / 2 + (w.cx >>> 2);
      w.cy = w.ay / 2 + w.by / 2 + (w.cy >>> 2);
      w.dx = w.ax / 2 + w.bx / 2 - (w.cx - (w.ax / 2 + w.bx / 2));
      w.dy = w.ay / 2 + w.by / 2 - (w.cy - (w.ay / 2 + w.by / 2));
    end else if (mode == 7) begin
      w.cx = w.ax; w.cy = w.ay;                 // shared endpoint
    end
    return w;
  endfunction

  task automatic send_pair(input spi_pkg::in_t w);
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  // drive stimulus
  initial begin
    int i;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    quiet_phase = 0;
    stim_done = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < N_DIRECTED; i++) begin
      expected_q.push_back(seg_has_golden[i] ? seg_golden[i] : crossing_of(seg_table[i]));
      send_pair(seg_table[i]);
    end
    for (i = 0; i < N_RANDOM; i++) begin
      spi_pkg::in_t w;
      w = random_pair();
      if (i > N_RANDOM - 150) quiet_phase = 1;
      expected_q.push_back(crossing_of(w));
      send_pair(w);
    end
    req_valid <= 1'b0;
    stim_done = 1;
  end

  // stall the result side
  initial begin
    rsp_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        rsp_ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      rsp_ready <= 1'b1;
    end
  end

  // compare results
  initial begin
    spi_pkg::out_t exp_w;
    err_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (expected_q.size() == 0) begin
          $display("%t unexpected word: actual %p", $time, rsp);
          err_cnt++;
        end else begin
          exp_w = expected_q.pop_front();
          if (rsp.kind !== exp_w.kind || rsp.px !== exp_w.px || rsp.py !== exp_w.py) begin
            $display("%t mismatch: expected %p actual %p", $time, exp_w, rsp);
            err_cnt++;
          end
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== segment_pair_intersection_core.f =====
src/spi_pkg.sv
src/spi_front.sv
src/spi_div_stage.sv
src/segment_pair_intersection_core.sv
tb/testbench.sv
